@@ sv/tsc_pkg.sv @@
// Shared types, constants and helper functions for the thin scatter covariance update.
package tsc_pkg;

  localparam int unsigned COV_FRAC_BITS  = 60;
  localparam int unsigned LOG_TABLE_BITS = 8;
  localparam int unsigned COV_SHIFT      = 64 - COV_FRAC_BITS;
  localparam int unsigned KNOTS          = (1 << LOG_TABLE_BITS) + 1;
  localparam int unsigned DIV_STEPS      = 128;
  localparam int unsigned SQRT_STEPS     = 32;

  localparam logic [63:0] ONE56    = 64'h0100_0000_0000_0000;
  localparam logic [63:0] ONE32    = 64'h0000_0001_0000_0000;
  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [31:0] C038_Q32 = 32'd163208757;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  localparam logic [7:0] CFG_FUDGE     = 8'd0;
  localparam logic [7:0] CFG_HIGHLAND  = 8'd1;
  localparam logic [7:0] CFG_MIN_RATIO = 8'd2;

  localparam logic [31:0] FUDGE_RST     = 32'd16777216;
  localparam logic [31:0] HIGHLAND_RST  = 32'd228170138;
  localparam logic [39:0] MIN_RATIO_RST = 40'd1;

  typedef struct packed {
    logic [63:0] cxx;
    logic [63:0] cyy;
    logic [63:0] cxy;
    logic        bad;
    logic        act;
    logic        xyneg;
    logic        lneg;
    logic [63:0] axx;
    logic [63:0] ayy;
    logic [63:0] axy;
    logic [63:0] norm2;
    logic [63:0] p2;
    logic [63:0] t;
    logic [63:0] r;
    logic [5:0]  m;
    logic [32:0] k0;
  } tsc_side_t;

  typedef struct packed {
    logic      v;
    tsc_side_t sd;
  } tsc_tag_t;

  typedef logic [32:0] knot_tab_t [KNOTS];

  // log2(1 + i/2^LOG_TABLE_BITS), Q.32, by repeated squaring
  function automatic logic [32:0] log_knot(int unsigned i);
    logic [63:0]  x;
    logic [127:0] sq;
    logic [32:0]  v;
    v = '0;
    if (i >= (1 << LOG_TABLE_BITS)) begin
      v = 33'h1_0000_0000;
    end else begin
      x = (64'd1 << 62) + (64'(i) << (62 - LOG_TABLE_BITS));
      for (int k = 31; k >= 0; k--) begin
        sq = {64'd0, x} * {64'd0, x};
        x  = sq[125:62];
        if (x[63]) begin
          v[k] = 1'b1;
          x    = x >> 1;
        end
      end
    end
    return v;
  endfunction

  function automatic knot_tab_t knot_table();
    knot_tab_t tab;
    for (int unsigned i = 0; i < KNOTS; i++) begin
      tab[i] = log_knot(i);
    end
    return tab;
  endfunction

  localparam knot_tab_t KNOT = knot_table();

  function automatic logic [63:0] sat64_shr(logic [191:0] p, int unsigned s);
    logic [191:0] q;
    q = p >> s;
    return (|q[191:64]) ? '1 : q[63:0];
  endfunction

  function automatic logic [127:0] sat128_shr(logic [191:0] p, int unsigned s);
    logic [191:0] q;
    q = p >> s;
    return (|q[191:128]) ? '1 : q[127:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] c, logic neg, logic [127:0] mag);
    logic [63:0] room;
    logic [63:0] res;
    if (!neg) begin
      room = POS_MAX - c;
      res  = (|mag[127:64] || mag[63:0] > room) ? POS_MAX : c + mag[63:0];
    end else begin
      room = c + NEG_MIN;
      res  = (|mag[127:64] || mag[63:0] > room) ? NEG_MIN : c - mag[63:0];
    end
    return res;
  endfunction

endpackage

@@ sv/tsc_ifs.sv @@
// Channel interfaces: track item input, covariance result output, register writes.
interface tsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] slope_x;
  logic signed [31:0] slope_y;
  logic [31:0]        momentum;
  logic [31:0]        wall_thick;
  logic [31:0]        rad_length;
  logic signed [63:0] cov_xx_in;
  logic signed [63:0] cov_yy_in;
  logic signed [63:0] cov_xy_in;
  modport source (output valid, slope_x, slope_y, momentum, wall_thick, rad_length,
                  cov_xx_in, cov_yy_in, cov_xy_in, input ready);
  modport sink (input valid, slope_x, slope_y, momentum, wall_thick, rad_length,
                cov_xx_in, cov_yy_in, cov_xy_in, output ready);
endinterface

interface tsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] cov_xx_out;
  logic signed [63:0] cov_yy_out;
  logic signed [63:0] cov_xy_out;
  logic               bad_length;
  modport source (output valid, cov_xx_out, cov_yy_out, cov_xy_out, bad_length,
                  input ready);
  modport sink (input valid, cov_xx_out, cov_yy_out, cov_xy_out, bad_length,
                output ready);
endinterface

interface tsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/thin_scatter_covariance_update.sv @@
// Top level of the thin scatter covariance update pipeline.
// Takes one track item per clock unless the pipeline holds, and returns one
// updated covariance per item; its depth is set by the two 128-stage restoring
// dividers (thickness ratio and division by p^2), the 32-stage square root,
// the two-stage normalizer and ten two-stage multipliers in series. When the
// result register is full and not taken, the whole pipeline holds. The user
// must write registers through cfg only while no item is in flight (the
// pipeline reads them at several different stages); the block does not check.
module thin_scatter_covariance_update import tsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tsc_in_if.sink    item,
  tsc_out_if.source result,
  tsc_cfg_if.sink   cfg
);

  logic [31:0] fudge;
  logic [31:0] highland;
  logic [39:0] min_ratio;
  logic        en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fudge     <= FUDGE_RST;
      highland  <= HIGHLAND_RST;
      min_ratio <= MIN_RATIO_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_FUDGE:     fudge     <= cfg.data[31:0];
        CFG_HIGHLAND:  highland  <= cfg.data[31:0];
        CFG_MIN_RATIO: min_ratio <= cfg.data[39:0];
        default: ;
      endcase
    end
  end

  assign en         = !result.valid || result.ready;
  assign item.ready = en;

  // stage 1: magnitudes
  logic        v1, v2;
  logic [31:0] txm, tym, p1, wall1, rad1;
  logic        xyneg1, xyneg2, bad2;
  logic [63:0] cxx1, cyy1, cxy1, cxx2, cyy2, cxy2;
  logic [63:0] tx2, ty2, axy2, p2sq;
  logic [31:0] wall2, rad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= item.valid;
      v2 <= v1;
    end
    if (en) begin
      txm    <= item.slope_x[31] ? 32'(-item.slope_x) : item.slope_x;
      tym    <= item.slope_y[31] ? 32'(-item.slope_y) : item.slope_y;
      xyneg1 <= item.slope_x[31] ^ item.slope_y[31];
      p1     <= (item.momentum == 32'd0) ? 32'd1 : item.momentum;
      wall1  <= item.wall_thick;
      rad1   <= item.rad_length;
      cxx1   <= item.cov_xx_in;
      cyy1   <= item.cov_yy_in;
      cxy1   <= item.cov_xy_in;
      tx2    <= {32'd0, txm} * {32'd0, txm};
      ty2    <= {32'd0, tym} * {32'd0, tym};
      axy2   <= {32'd0, txm} * {32'd0, tym};
      p2sq   <= {32'd0, p1} * {32'd0, p1};
      wall2  <= wall1;
      rad2   <= rad1;
      bad2   <= rad1 == 32'd0;
      xyneg2 <= xyneg1;
      cxx2   <= cxx1;
      cyy2   <= cyy1;
      cxy2   <= cxy1;
    end
  end

  tsc_tag_t a0, a1, b0, b1, c1, c2, d1, d2, e1, f1, g1, h1, i1, j1, k1, l1, m1;
  tsc_tag_t n1a, n1b, n1c;
  logic [127:0] quo_t, quo_p;
  logic [31:0]  root;
  logic [191:0] prod_r, prod_f, prod_ln, prod_c, prod_h, prod_h2, prod_x, prod_n, prod_fg;
  logic [191:0] prod_xx, prod_yy, prod_xy;
  logic [63:0]  nrm;
  logic [5:0]   msb;

  always_comb begin
    a0          = '0;
    a0.v        = v2;
    a0.sd.cxx   = cxx2;
    a0.sd.cyy   = cyy2;
    a0.sd.cxy   = cxy2;
    a0.sd.bad   = bad2;
    a0.sd.xyneg = xyneg2;
    a0.sd.axx   = ONE56 + tx2;
    a0.sd.ayy   = ONE56 + ty2;
    a0.sd.axy   = axy2;
    a0.sd.norm2 = ONE56 + tx2 + ty2;
    a0.sd.p2    = p2sq;
  end

  tsc_div u_div_t (
    .clk(clk), .rst(rst), .en(en), .tag_in(a0),
    .num({64'd0, wall2, 32'd0}), .den({32'd0, rad2}),
    .tag_out(a1), .quo(quo_t)
  );

  always_comb begin
    b0        = a1;
    b0.sd.t   = quo_t[63:0];
    b0.sd.act = quo_t[63:0] > {24'd0, min_ratio};
  end

  tsc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .tag_in(b0), .x(b0.sd.norm2),
    .tag_out(b1), .root(root)
  );

  tsc_mul u_mul_r (
    .clk(clk), .rst(rst), .en(en), .tag_in(b1),
    .a({64'd0, b1.sd.t}), .b({32'd0, root}),
    .tag_out(c1), .prod(prod_r)
  );

  always_comb begin
    c2      = c1;
    c2.sd.r = sat64_shr(prod_r, 28);
  end

  tsc_norm u_norm (
    .clk(clk), .rst(rst), .en(en), .tag_in(c2), .r(c2.sd.r),
    .tag_out(d1), .n(nrm), .m(msb)
  );

  logic [LOG_TABLE_BITS-1:0] idx;
  logic [31:0]               rem;
  logic [32:0]               kn0, kn1, kdiff;

  always_comb begin
    idx      = nrm[62 -: LOG_TABLE_BITS];
    rem      = nrm[62 - LOG_TABLE_BITS -: 32];
    kn0      = KNOT[idx];
    kn1      = KNOT[{1'b0, idx} + 1'b1];
    kdiff    = kn1 - kn0;
    d2       = d1;
    d2.sd.m  = msb;
    d2.sd.k0 = kn0;
  end

  tsc_mul u_mul_f (
    .clk(clk), .rst(rst), .en(en), .tag_in(d2),
    .a({95'd0, kdiff}), .b({32'd0, rem}),
    .tag_out(e1), .prod(prod_f)
  );

  logic [63:0] frac, lmag;
  tsc_tag_t    e2;

  always_comb begin
    frac = {31'd0, e1.sd.k0} + prod_f[95:32];
    e2   = e1;
    if (e1.sd.m >= 6'd32) begin
      e2.sd.lneg = 1'b0;
      lmag       = {26'd0, e1.sd.m - 6'd32, 32'd0} + frac;
    end else begin
      e2.sd.lneg = 1'b1;
      lmag       = {26'd0, 6'd32 - e1.sd.m, 32'd0} - frac;
    end
  end

  tsc_mul u_mul_ln (
    .clk(clk), .rst(rst), .en(en), .tag_in(e2),
    .a({64'd0, lmag}), .b({32'd0, LN2_Q32}),
    .tag_out(f1), .prod(prod_ln)
  );

  tsc_mul u_mul_c (
    .clk(clk), .rst(rst), .en(en), .tag_in(f1),
    .a({64'd0, sat64_shr(prod_ln, 32)}), .b({32'd0, C038_Q32}),
    .tag_out(g1), .prod(prod_c)
  );

  logic [63:0] term, gain;

  always_comb begin
    term = sat64_shr(prod_c, 32);
    gain = g1.sd.lneg ? ONE32 - term : ONE32 + term;
  end

  tsc_mul u_mul_h (
    .clk(clk), .rst(rst), .en(en), .tag_in(g1),
    .a({96'd0, highland}), .b(gain),
    .tag_out(h1), .prod(prod_h)
  );

  logic [63:0] hval;
  assign hval = sat64_shr(prod_h, 24);

  tsc_mul u_mul_h2 (
    .clk(clk), .rst(rst), .en(en), .tag_in(h1),
    .a({64'd0, hval}), .b(hval),
    .tag_out(i1), .prod(prod_h2)
  );

  logic [63:0] h2;
  assign h2 = i1.sd.act ? sat64_shr(prod_h2, 32) : 64'd0;

  tsc_mul u_mul_x (
    .clk(clk), .rst(rst), .en(en), .tag_in(i1),
    .a({64'd0, i1.sd.r}), .b(h2),
    .tag_out(j1), .prod(prod_x)
  );

  tsc_mul u_mul_n (
    .clk(clk), .rst(rst), .en(en), .tag_in(j1),
    .a(prod_x[127:0]), .b(j1.sd.norm2),
    .tag_out(k1), .prod(prod_n)
  );

  tsc_mul u_mul_fg (
    .clk(clk), .rst(rst), .en(en), .tag_in(k1),
    .a(sat128_shr(prod_n, 56)), .b({32'd0, fudge}),
    .tag_out(l1), .prod(prod_fg)
  );

  tsc_div u_div_p (
    .clk(clk), .rst(rst), .en(en), .tag_in(l1),
    .num(sat128_shr(prod_fg, 24)), .den(l1.sd.p2),
    .tag_out(m1), .quo(quo_p)
  );

  tsc_mul u_mul_xx (
    .clk(clk), .rst(rst), .en(en), .tag_in(m1),
    .a(quo_p), .b(m1.sd.axx),
    .tag_out(n1a), .prod(prod_xx)
  );

  tsc_mul u_mul_yy (
    .clk(clk), .rst(rst), .en(en), .tag_in(m1),
    .a(quo_p), .b(m1.sd.ayy),
    .tag_out(n1b), .prod(prod_yy)
  );

  tsc_mul u_mul_xy (
    .clk(clk), .rst(rst), .en(en), .tag_in(m1),
    .a(quo_p), .b(m1.sd.axy),
    .tag_out(n1c), .prod(prod_xy)
  );

  logic [127:0] mag_xx, mag_yy, mag_xy;

  always_comb begin
    mag_xx = sat128_shr(prod_xx, 56) >> COV_SHIFT;
    mag_yy = sat128_shr(prod_yy, 56) >> COV_SHIFT;
    mag_xy = sat128_shr(prod_xy, 56) >> COV_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= n1a.v && n1b.v && n1c.v;
    end
    if (en) begin
      result.bad_length <= n1a.sd.bad;
      if (n1a.sd.bad) begin
        result.cov_xx_out <= n1a.sd.cxx;
        result.cov_yy_out <= n1a.sd.cyy;
        result.cov_xy_out <= n1a.sd.cxy;
      end else begin
        result.cov_xx_out <= add_sat(n1a.sd.cxx, 1'b0, mag_xx);
        result.cov_yy_out <= add_sat(n1a.sd.cyy, 1'b0, mag_yy);
        result.cov_xy_out <= add_sat(n1a.sd.cxy, n1a.sd.xyneg, mag_xy);
      end
    end
  end

endmodule

@@ sv/tsc_mul.sv @@
// Two-stage 128x64 multiplier built from registered 32x32 partial products.
module tsc_mul import tsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  tsc_tag_t     tag_in,
  input  logic [127:0] a,
  input  logic [63:0]  b,
  output tsc_tag_t     tag_out,
  output logic [191:0] prod
);

  logic [63:0] pp [8];
  tsc_tag_t    tag1;
  logic [191:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.v <= 1'b0;
    end else if (en) begin
      tag1.v <= tag_in.v;
    end
    if (en) begin
      tag1.sd <= tag_in.sd;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp[i*2+j] <= a[32*i +: 32] * b[32*j +: 32];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        sum = sum + ({128'd0, pp[i*2+j]} << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.v <= 1'b0;
    end else if (en) begin
      tag_out.v <= tag1.v;
    end
    if (en) begin
      tag_out.sd <= tag1.sd;
      prod       <= sum;
    end
  end

endmodule

@@ sv/tsc_div.sv @@
// Pipelined restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit a stage.
module tsc_div import tsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  tsc_tag_t     tag_in,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output tsc_tag_t     tag_out,
  output logic [127:0] quo
);

  logic [63:0]  rm [DIV_STEPS];
  logic [127:0] nq [DIV_STEPS];
  logic [63:0]  dn [DIV_STEPS];
  tsc_tag_t     tg [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    logic [63:0]  rin;
    logic [127:0] nin;
    logic [63:0]  din;
    tsc_tag_t     tin;
    logic [64:0]  sh;
    logic [64:0]  dif;
    logic         ge;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign nin = num;
      assign din = den;
      assign tin = tag_in;
    end else begin : g_next
      assign rin = rm[k-1];
      assign nin = nq[k-1];
      assign din = dn[k-1];
      assign tin = tg[k-1];
    end

    assign sh  = {rin, nin[127]};
    assign dif = sh - {1'b0, din};
    assign ge  = sh >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k].v <= 1'b0;
      end else if (en) begin
        tg[k].v <= tin.v;
      end
      if (en) begin
        tg[k].sd <= tin.sd;
        rm[k]    <= ge ? dif[63:0] : sh[63:0];
        nq[k]    <= {nin[126:0], ge};
        dn[k]    <= din;
      end
    end
  end

  assign tag_out = tg[DIV_STEPS-1];
  assign quo     = nq[DIV_STEPS-1];

endmodule

@@ sv/tsc_sqrt.sv @@
// Pipelined integer square root of a 64-bit value, one root bit a stage.
module tsc_sqrt import tsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  tsc_tag_t    tag_in,
  input  logic [63:0] x,
  output tsc_tag_t    tag_out,
  output logic [31:0] root
);

  logic [63:0] rs [SQRT_STEPS];
  logic [63:0] xr [SQRT_STEPS];
  tsc_tag_t    tg [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] rin;
    logic [63:0] xin;
    tsc_tag_t    tin;
    logic [63:0] tr;
    logic        ge;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign xin = x;
      assign tin = tag_in;
    end else begin : g_next
      assign rin = rs[k-1];
      assign xin = xr[k-1];
      assign tin = tg[k-1];
    end

    assign tr = rin + BIT;
    assign ge = xin >= tr;

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k].v <= 1'b0;
      end else if (en) begin
        tg[k].v <= tin.v;
      end
      if (en) begin
        tg[k].sd <= tin.sd;
        rs[k]    <= ge ? (rin >> 1) + BIT : rin >> 1;
        xr[k]    <= ge ? xin - tr : xin;
      end
    end
  end

  assign tag_out = tg[SQRT_STEPS-1];
  assign root    = rs[SQRT_STEPS-1][31:0];

endmodule

@@ sv/tsc_norm.sv @@
// Two-stage leading-one normalizer: shifts the top set bit to bit 63 and gives its index.
module tsc_norm import tsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  tsc_tag_t    tag_in,
  input  logic [63:0] r,
  output tsc_tag_t    tag_out,
  output logic [63:0] n,
  output logic [5:0]  m
);

  tsc_tag_t    tag1;
  logic [63:0] n1;
  logic [2:0]  zh;
  logic [63:0] a0, a1, a2, b0, b1, b2;
  logic [2:0]  zh_c, zl_c;

  always_comb begin
    zh_c[2] = ~|r[63:32];
    a0      = zh_c[2] ? r << 32 : r;
    zh_c[1] = ~|a0[63:48];
    a1      = zh_c[1] ? a0 << 16 : a0;
    zh_c[0] = ~|a1[63:56];
    a2      = zh_c[0] ? a1 << 8 : a1;
    zl_c[2] = ~|n1[63:60];
    b0      = zl_c[2] ? n1 << 4 : n1;
    zl_c[1] = ~|b0[63:62];
    b1      = zl_c[1] ? b0 << 2 : b0;
    zl_c[0] = ~b1[63];
    b2      = zl_c[0] ? b1 << 1 : b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.v    <= 1'b0;
      tag_out.v <= 1'b0;
    end else if (en) begin
      tag1.v    <= tag_in.v;
      tag_out.v <= tag1.v;
    end
    if (en) begin
      tag1.sd    <= tag_in.sd;
      n1         <= a2;
      zh         <= zh_c;
      tag_out.sd <= tag1.sd;
      n          <= b2;
      m          <= ~{zh, zl_c};
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench for thin_scatter_covariance_update: random and directed tracks checked against a predictor.
`timescale 1ns / 1ps

import tsc_pkg::*;

typedef struct {
  logic [31:0] sx, sy, mom, wall, rad;
  logic [63:0] cxx, cyy, cxy;
} track_t;

typedef struct {
  logic [63:0] cxx, cyy, cxy;
  logic        bad;
} cov_res_t;

class cov_scoreboard;
  logic [31:0] fudge, highland;
  logic [39:0] min_ratio;
  logic [32:0] knots [KNOTS];
  cov_res_t    pending [$];
  int          errors, checked;

  function new();
    logic [63:0]  x;
    logic [127:0] sq;
    fudge = FUDGE_RST;
    highland = HIGHLAND_RST;
    min_ratio = MIN_RATIO_RST;
    errors = 0;
    checked = 0;
    for (int i = 0; i < KNOTS; i++) begin
      knots[i] = '0;
      if (i == (1 << LOG_TABLE_BITS)) begin
        knots[i] = 33'h1_0000_0000;
      end else begin
        x = 64'h4000_0000_0000_0000 + (64'(i) << (62 - LOG_TABLE_BITS));
        for (int k = 31; k >= 0; k--) begin
          sq = 128'(x) * 128'(x);
          x = sq[125:62];
          if (x[63]) begin
            knots[i][k] = 1'b1;
            x = x >> 1;
          end
        end
      end
    end
  endfunction

  function logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> s;
    return (|p[127:64]) ? '1 : p[63:0];
  endfunction

  function logic [127:0] wide_mul(logic [127:0] a, logic [63:0] b, int s);
    logic [191:0] p;
    p = (192'(a) * 192'(b)) >> s;
    return (|p[191:128]) ? '1 : p[127:0];
  endfunction

  function logic [63:0] sum_clamp(logic [63:0] c, bit neg, logic [127:0] mag);
    logic signed [129:0] acc;
    acc = $signed({{66{c[63]}}, c});
    if (neg) acc = acc - $signed({2'b0, mag});
    else acc = acc + $signed({2'b0, mag});
    if (acc > $signed({66'b0, POS_MAX})) return POS_MAX;
    if (acc < $signed({{66{1'b1}}, NEG_MIN})) return NEG_MIN;
    return acc[63:0];
  endfunction

  function logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function void note_track(track_t tr);
    cov_res_t     e;
    logic [63:0]  txm, tym, tx2, ty2, norm2, p, t, s, r, n, idx, rem, frac;
    logic [63:0]  lmag, lnm, term, g, h, h2;
    logic [127:0] x, p1;
    bit           lneg, xyneg;
    int           m;
    txm = tr.sx[31] ? 64'h1_0000_0000 - 64'(tr.sx) : 64'(tr.sx);
    tym = tr.sy[31] ? 64'h1_0000_0000 - 64'(tr.sy) : 64'(tr.sy);
    xyneg = tr.sx[31] ^ tr.sy[31];
    tx2 = txm * txm;
    ty2 = tym * tym;
    norm2 = ONE56 + tx2 + ty2;
    x = '0;
    if (tr.rad == 0) begin
      e = '{tr.cxx, tr.cyy, tr.cxy, 1'b1};
      pending.push_back(e);
      return;
    end
    p = (tr.mom == 0) ? 64'd1 : 64'(tr.mom);
    t = {tr.wall, 32'b0} / 64'(tr.rad);
    if (t > 64'(min_ratio)) begin
      s = root_floor(norm2);
      r = mul_trunc(s, t, 28);
      if (r != 0) begin
        m = 63;
        while (!r[m]) m--;
        n = r << (63 - m);
        idx = 64'(n[62:63-LOG_TABLE_BITS]);
        rem = 64'(n[62-LOG_TABLE_BITS -: 32]);
        frac = 64'(knots[idx]) + (((64'(knots[idx+1]) - 64'(knots[idx])) * rem) >> 32);
        lneg = (m < 32);
        lmag = lneg ? ((64'(32 - m) << 32) - frac) : ((64'(m - 32) << 32) + frac);
        lnm = mul_trunc(lmag, 64'(LN2_Q32), 32);
        term = mul_trunc(lnm, 64'(C038_Q32), 32);
        g = lneg ? ONE32 - term : ONE32 + term;
        h = mul_trunc(64'(highland), g, 24);
        h2 = mul_trunc(h, h, 32);
        x = 128'(r) * 128'(h2);
        x = wide_mul(x, norm2, 56);
        x = wide_mul(x, 64'(fudge), 24);
        x = x / 128'(p * p);
      end
    end
    e.cxx = sum_clamp(tr.cxx, 0, wide_mul(x, ONE56 + tx2, 56) >> COV_SHIFT);
    e.cyy = sum_clamp(tr.cyy, 0, wide_mul(x, ONE56 + ty2, 56) >> COV_SHIFT);
    p1 = wide_mul(x, txm * tym, 56) >> COV_SHIFT;
    e.cxy = sum_clamp(tr.cxy, xyneg, p1);
    e.bad = 1'b0;
    pending.push_back(e);
  endfunction

  function void check_result(cov_res_t got);
    cov_res_t e;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: result with nothing pending: %h %h %h %b",
                                 got.cxx, got.cyy, got.cxy, got.bad);
      return;
    end
    e = pending.pop_front();
    if (e.cxx !== got.cxx || e.cyy !== got.cyy || e.cxy !== got.cxy ||
        e.bad !== got.bad) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: mismatch on result %0d", checked);
        $display("  exp xx=%h yy=%h xy=%h bad=%b", e.cxx, e.cyy, e.cxy, e.bad);
        $display("  got xx=%h yy=%h xy=%h bad=%b", got.cxx, got.cyy, got.cxy, got.bad);
      end
    end
  endfunction
endclass

module tb_top;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsc_in_if  item ();
  tsc_out_if result ();
  tsc_cfg_if cfg ();

  thin_scatter_covariance_update uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  cov_scoreboard sb = new();
  int  idle_cycles = 0;
  int  n_tracks = 0;
  int  stall_left = 0;
  bit  quiet = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    item.valid = 1'b0;
    item.slope_x = '0;
    item.slope_y = '0;
    item.momentum = '0;
    item.wall_thick = '0;
    item.rad_length = '0;
    item.cov_xx_in = '0;
    item.cov_yy_in = '0;
    item.cov_xy_in = '0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_FUDGE;
    cfg.data = '0;
  end

  // transfers are sampled mid-cycle, inputs only move at the rising edge
  always @(negedge clk) begin
    cov_res_t got;
    if (!rst && item.valid && item.ready) begin
      sb.note_track('{item.slope_x, item.slope_y, item.momentum, item.wall_thick,
                      item.rad_length, item.cov_xx_in, item.cov_yy_in, item.cov_xy_in});
      n_tracks++;
    end
    if (!rst && result.valid && result.ready) begin
      got = '{result.cov_xx_out, result.cov_yy_out, result.cov_xy_out, result.bad_length};
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item.valid && item.ready) || (result.valid && result.ready) ||
                 (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (quiet) begin
      result.ready <= 1'b1;
    end else if (stall_left > 0) begin
      result.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end
  end

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    if ($urandom_range(0, 14) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic push_track(track_t tr);
    int gap;
    item.valid <= 1'b1;
    item.slope_x <= tr.sx;
    item.slope_y <= tr.sy;
    item.momentum <= tr.mom;
    item.wall_thick <= tr.wall;
    item.rad_length <= tr.rad;
    item.cov_xx_in <= tr.cxx;
    item.cov_yy_in <= tr.cyy;
    item.cov_xy_in <= tr.cxy;
    do @(negedge clk); while (!item.ready);
    @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [7:0] idx, logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == CFG_FUDGE) sb.fudge = val[31:0];
    else if (idx == CFG_HIGHLAND) sb.highland = val[31:0];
    else sb.min_ratio = val[39:0];
    @(posedge clk);
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic track_t rnd_track();
    track_t tr;
    if ($urandom_range(0, 7) == 0) begin
      tr = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             rnd64(), rnd64(), rnd64()};
    end else begin
      tr.sx = $signed($urandom_range(0, 32'h1000_0000 << $urandom_range(0, 3))) *
              ($urandom_range(0, 1) ? 1 : -1);
      tr.sy = $signed($urandom_range(0, 32'h1000_0000 << $urandom_range(0, 3))) *
              ($urandom_range(0, 1) ? 1 : -1);
      tr.mom = ($urandom_range(0, 30) == 0) ? 32'd0 : $urandom_range(1, 200000);
      tr.wall = $urandom_range(1, 32'h0010_0000);
      tr.rad = ($urandom_range(0, 40) == 0) ? 32'd0 : $urandom_range(32'h0001_0000, 32'h0400_0000);
      tr.cxx = rnd64() >> $urandom_range(1, 40);
      tr.cyy = rnd64() >> $urandom_range(1, 40);
      tr.cxy = rnd64() >>> $urandom_range(0, 40);
    end
    return tr;
  endfunction

  task automatic run_random(int count);
    repeat (count) push_track(rnd_track());
  endtask

  initial begin
    track_t d [$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    d.push_back('{32'h1000_0000, 32'h0800_0000, 32'd1000, 32'h0001_0000, 32'h0010_0000,
                  64'h0100_0000_0000_0000, 64'h0100_0000_0000_0000, 64'd0});
    d.push_back('{32'h1000_0000, 32'h1000_0000, 32'd1000, 32'h0001_0000, 32'd0,
                  64'h1234_5678_9abc_def0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF});
    d.push_back('{32'h0, 32'h0, 32'd0, 32'h0001_0000, 32'h0001_0000, 64'd0, 64'd0, 64'd0});
    d.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0000});
    d.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1,
                  64'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FF00});
    d.push_back('{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                  64'h8000_0000_0000_0000, 64'd5, 64'd0});
    d.push_back('{32'hF000_0000, 32'h1000_0000, 32'd500, 32'h0000_0001, 32'hFFFF_FFFF,
                  64'd1, 64'd1, 64'd1});
    d.push_back('{32'hF000_0000, 32'h1000_0000, 32'd3, 32'h0100_0000, 32'h0000_0100,
                  64'd0, 64'd0, 64'h8000_0000_0000_0010});
    d.push_back('{32'h0000_0001, 32'hFFFF_FFFF, 32'd10, 32'h0000_1000, 32'h0100_0000,
                  64'd0, 64'd0, 64'd0});
    d.push_back('{32'h0, 32'h0, 32'd100, 32'h0001_0000, 32'h0000_FFFF, 64'd0, 64'd0, 64'd0});
    d.push_back('{32'h0, 32'h0, 32'd100, 32'h0001_0000, 32'h0001_0000, 64'd0, 64'd0, 64'd0});
    d.push_back('{32'h0, 32'h0, 32'd100, 32'h0000_0001, 32'hFFFF_FFFF, 64'd0, 64'd0, 64'd0});
    d.push_back('{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
    foreach (d[i]) push_track(d[i]);
    run_random(260);
    drain();

    write_reg(CFG_FUDGE, 64'hFFFF_FFFF);
    write_reg(CFG_HIGHLAND, 64'hFFFF_FFFF);
    write_reg(CFG_MIN_RATIO, 64'd0);
    foreach (d[i]) push_track(d[i]);
    run_random(250);
    drain();

    quiet = 1;
    write_reg(CFG_FUDGE, 64'd0);
    write_reg(CFG_HIGHLAND, 64'd0);
    write_reg(CFG_MIN_RATIO, 64'hFF_FFFF_FFFF);
    run_random(270);
    drain();

    quiet = 0;
    write_reg(CFG_MIN_RATIO, 64'h00_0000_0000);
    write_reg(CFG_FUDGE, 64'h0100_0000);
    write_reg(CFG_HIGHLAND, 64'h0D99_999A);
    run_random(270);
    drain();

    write_reg(CFG_FUDGE, 64'($urandom()));
    write_reg(CFG_HIGHLAND, 64'($urandom()));
    write_reg(CFG_MIN_RATIO, 64'({$urandom_range(0, 255), $urandom()} >> $urandom_range(0, 39)));
    run_random(270);
    drain();
    repeat (400) @(posedge clk);

    $display("Sent %0d tracks over five register settings, %0d covariance results checked.",
             n_tracks, sb.checked);
    $display("Settings included full-scale, zero and default fudge, scale and ratio floor.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, still pending: %0d", sb.errors, sb.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/tsc_pkg.sv
sv/tsc_ifs.sv
sv/tsc_mul.sv
sv/tsc_div.sv
sv/tsc_sqrt.sv
sv/tsc_norm.sv
sv/thin_scatter_covariance_update.sv
bench/tb_top.sv
